FILE: src/asmd_pkg.sv
// shared types and constants for the audio and mechanism stream splitter
package asmd_pkg;

    // reset value of the mechanism update period
    localparam logic [15:0] MECH_PERIOD_RESET = 16'd746;

    // widths of the length and byte counters
    localparam int LEN_W = 24;

    // status codes reported with each result word
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_ABORTED  = 2'd3;

    // index of the last header byte
    localparam logic [1:0] HDR_LAST = 2'd3;

    // one queued input word
    typedef struct packed {
        logic       abort;
        logic [7:0] stream_byte;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] pins_value;
        logic       pins_valid;
        logic [7:0] dac_value;
        logic       dac_valid;
    } out_word_t;

endpackage

FILE: src/asmd_queue.sv
// input front end: accepts stream words into a short queue
module asmd_queue
    import asmd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    output logic     q_valid,
    input  logic     q_pop,
    output in_word_t q_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    in_word_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;

    // handshake and head of queue
    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_word   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

FILE: src/asmd_engine.sv
// back end: header parse, payload split and registered result word
module asmd_engine
    import asmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic      q_valid,
    output logic      q_pop,
    input  in_word_t  q_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic [15:0]      mech_period_reg;
    logic             in_payload_reg, in_payload_next;
    logic [1:0]       header_index_reg, header_index_next;
    logic [LEN_W-1:0] payload_length_reg, payload_length_next;
    logic [LEN_W-1:0] bytes_taken_reg, bytes_taken_next;
    logic [15:0]      period_left_reg, period_left_next;
    logic [3:0]       held_nibble_reg, held_nibble_next;
    logic             nibble_pending_reg, nibble_pending_next;
    logic             audio_due_reg, audio_due_next;
    logic             out_valid_reg;
    out_word_t        out_word_reg, out_word_next;
    logic             audio;
    logic [LEN_W-1:0] taken_base;
    logic [LEN_W:0]   taken_sum;
    logic [7:0]       b;

    assign b         = q_word.stream_byte;
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // per-word decision
    always_comb
    begin
        in_payload_next     = in_payload_reg;
        header_index_next   = header_index_reg;
        payload_length_next = payload_length_reg;
        bytes_taken_next    = bytes_taken_reg;
        period_left_next    = period_left_reg;
        held_nibble_next    = held_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        audio_due_next      = audio_due_reg;
        out_word_next       = '0;
        audio               = 1'b0;
        taken_base          = bytes_taken_reg;

        if (q_word.abort)
        begin
            in_payload_next     = 1'b0;
            header_index_next   = '0;
            payload_length_next = '0;
            bytes_taken_next    = '0;
            period_left_next    = '0;
            held_nibble_next    = '0;
            nibble_pending_next = 1'b0;
            audio_due_next      = 1'b0;
            out_word_next.status = ST_ABORTED;
        end
        else if (!in_payload_reg)
        begin
            if (header_index_reg == HDR_LAST)
            begin
                // top byte decides; stream state starts fresh
                header_index_next   = '0;
                bytes_taken_next    = '0;
                period_left_next    = '0;
                held_nibble_next    = '0;
                nibble_pending_next = 1'b0;
                audio_due_next      = 1'b0;
                if (b != 8'd0)
                begin
                    payload_length_next  = '0;
                    out_word_next.status = ST_REJECTED;
                end
                else if (payload_length_reg == '0)
                begin
                    out_word_next.status = ST_FINISHED;
                end
                else
                begin
                    in_payload_next = 1'b1;
                end
            end
            else
            begin
                // little-endian length bytes
                case (header_index_reg)
                    2'd0:    payload_length_next[7:0]   = b;
                    2'd1:    payload_length_next[15:8]  = b;
                    default: payload_length_next[23:16] = b;
                endcase
                header_index_next = header_index_reg + 2'd1;
            end
        end
        else if (audio_due_reg)
        begin
            audio_due_next = 1'b0;
            audio          = 1'b1;
        end
        else if (period_left_reg == '0)
        begin
            period_left_next = mech_period_reg - 16'd1;
            out_word_next.pins_valid = 1'b1;
            if (!nibble_pending_reg)
            begin
                // control byte: low nibble now, high nibble held
                out_word_next.pins_value = b[3:0];
                held_nibble_next         = b[7:4];
                nibble_pending_next      = 1'b1;
                bytes_taken_next         = bytes_taken_reg + 1'b1;
                audio_due_next           = 1'b1;
            end
            else
            begin
                out_word_next.pins_value = held_nibble_reg;
                nibble_pending_next      = 1'b0;
                audio                    = 1'b1;
            end
        end
        else
        begin
            period_left_next = period_left_reg - 16'd1;
            audio            = 1'b1;
        end

        // audio byte and end-of-payload test
        taken_sum = {1'b0, taken_base} + {{LEN_W{1'b0}}, 1'b1};
        if (audio)
        begin
            out_word_next.dac_valid = 1'b1;
            out_word_next.dac_value = b;
            bytes_taken_next        = taken_sum[LEN_W-1:0];
            if (taken_sum >= {1'b0, payload_length_reg})
            begin
                in_payload_next      = 1'b0;
                header_index_next    = '0;
                payload_length_next  = '0;
                bytes_taken_next     = '0;
                period_left_next     = '0;
                held_nibble_next     = '0;
                nibble_pending_next  = 1'b0;
                audio_due_next       = 1'b0;
                out_word_next.status = ST_FINISHED;
            end
        end
    end

    // control state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mech_period_reg    <= MECH_PERIOD_RESET;
            in_payload_reg     <= 1'b0;
            header_index_reg   <= '0;
            payload_length_reg <= '0;
            bytes_taken_reg    <= '0;
            period_left_reg    <= '0;
            held_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
            audio_due_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mech_period_reg <= cfg_wdata;
            end
            if (q_pop)
            begin
                in_payload_reg     <= in_payload_next;
                header_index_reg   <= header_index_next;
                payload_length_reg <= payload_length_next;
                bytes_taken_reg    <= bytes_taken_next;
                period_left_reg    <= period_left_next;
                held_nibble_reg    <= held_nibble_next;
                nibble_pending_reg <= nibble_pending_next;
                audio_due_reg      <= audio_due_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

FILE: src/audio_mech_stream_demux_top.sv
// Splits a stored byte stream into DAC samples and four-pin mechanism
// updates. The first four words form a little-endian payload length; a
// nonzero top byte rejects the header (status 2), a zero length finishes at
// once (status 1). Payload words yield exactly one result word each. A word
// with the abort bit set cancels the stream (status 3). mech_period counts
// audio samples between mechanism updates, 0 acting as 65536. The block
// takes one word per clock while the queue has room: input words enter a queue
// of QUEUE_DEPTH entries; the decision logic retires one word per cycle
// into a result register when it is free or taken, so input and output
// stall independently. Each word is queued, then its result registered.
module audio_mech_stream_demux_top
    import asmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // mech_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // stream_byte[7:0], abort[8], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // dac_valid[0], dac_value[8:1],
                                        // pins_valid[9], pins_value[13:10],
                                        // status[15:14]
);

    in_word_t  in_word;
    in_word_t  q_word;
    out_word_t out_word;
    logic      q_valid;
    logic      q_pop;

    // unpack input word
    assign in_word.stream_byte = s_axis_tdata[7:0];
    assign in_word.abort       = s_axis_tdata[8];

    // input queue
    asmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word)
    );

    // decision engine
    asmd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // pack result word
    assign m_axis_tdata = out_word;

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the audio and mechanism stream splitter
`timescale 1ns / 1ps

module testbench;
    import asmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int ITEM_TARGET    = 1450;
    localparam int PHASES         = 8;
    localparam int PAYLOAD_GUARD  = 400;

    // predictor of the splitter plus the queue of result words it still owes
    class split_checker;
        logic [15:0] period = MECH_PERIOD_RESET;
        bit          in_payload;
        logic [1:0]  hdr_idx;
        logic [31:0] pay_len;
        logic [31:0] taken;
        logic [15:0] left;
        logic [3:0]  held;
        bit          nib_pending;
        bit          audio_due;
        out_word_t   due_words[$];
        int          errors;
        int          words_seen;

        // start from the reset state of the stream
        function new();
            clear_stream();
        endfunction

        function void clear_stream();
            in_payload  = 0;
            hdr_idx     = '0;
            pay_len     = '0;
            taken       = '0;
            left        = '0;
            held        = '0;
            nib_pending = 0;
            audio_due   = 0;
        endfunction

        function void set_period(logic [15:0] value);
            period = value;
        endfunction

        // work out the result word caused by one input word
        function out_word_t split_byte(in_word_t w);
            out_word_t   r;
            bit          audio;
            logic [31:0] len;
            r     = '0;
            r.status = ST_RUNNING;
            audio = 0;
            if (w.abort)
            begin
                clear_stream();
                r.status = ST_ABORTED;
            end
            else if (!in_payload)
            begin
                pay_len = pay_len | ({24'd0, w.stream_byte} << (8 * hdr_idx));
                if (hdr_idx == HDR_LAST)
                begin
                    len = pay_len;
                    clear_stream();
                    if (len[31:24] != 8'd0)
                        r.status = ST_REJECTED;
                    else if (len == 32'd0)
                        r.status = ST_FINISHED;
                    else
                    begin
                        in_payload = 1;
                        pay_len    = len;
                    end
                end
                else
                    hdr_idx = hdr_idx + 2'd1;
            end
            else if (audio_due)
            begin
                audio_due = 0;
                audio     = 1;
            end
            else if (left == 16'd0)
            begin
                left         = period - 16'd1;
                r.pins_valid = 1'b1;
                if (!nib_pending)
                begin
                    // control byte: low nibble now, high nibble next update
                    r.pins_value = w.stream_byte[3:0];
                    held         = w.stream_byte[7:4];
                    nib_pending  = 1;
                    taken        = taken + 32'd1;
                    audio_due    = 1;
                end
                else
                begin
                    // held nibble goes out, this byte is the pass's sample
                    r.pins_value = held;
                    nib_pending  = 0;
                    audio        = 1;
                end
            end
            else
            begin
                left  = left - 16'd1;
                audio = 1;
            end

            // audio byte and the end-of-payload test
            if (audio)
            begin
                r.dac_valid = 1'b1;
                r.dac_value = w.stream_byte;
                taken       = taken + 32'd1;
                if (taken >= pay_len)
                begin
                    clear_stream();
                    r.status = ST_FINISHED;
                end
            end
            return r;
        endfunction

        function void note_input(in_word_t w);
            due_words.push_back(split_byte(w));
        endfunction

        task report(string msg);
            $display("mismatch at result word %0d: %s", words_seen, msg);
            errors++;
        endtask

        // compare one accepted result word with the oldest prediction
        task check_result(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0)
                report($sformatf("unexpected word %h", got));
            else
            begin
                want = due_words.pop_front();
                if (got.dac_valid !== want.dac_valid)
                    report($sformatf("dac_valid %b, want %b", got.dac_valid, want.dac_valid));
                if (got.dac_value !== want.dac_value)
                    report($sformatf("dac_value %h, want %h", got.dac_value, want.dac_value));
                if (got.pins_valid !== want.pins_valid)
                    report($sformatf("pins_valid %b, want %b", got.pins_valid,
                                     want.pins_valid));
                if (got.pins_value !== want.pins_value)
                    report($sformatf("pins_value %h, want %h", got.pins_value,
                                     want.pins_value));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
            end
            words_seen++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    split_checker sb;
    int           snd_pct;
    int           recv_pct;
    bit           hold_req;
    int           hold_left;
    int           quiet_cycles;
    int           n_sent;

    audio_mech_stream_demux_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock and known input levels from time zero
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        snd_pct       = 0;
        recv_pct      = 0;
        hold_req      = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        n_sent        = 0;
        sb            = new;
    end

    always #10 clk = ~clk;

    // result side: check accepted words, then pick next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(out_word_t'(m_axis_tdata));
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one input word and wait until it is taken
    task send_word(logic [7:0] b, logic ab);
        in_word_t w;
        w.stream_byte = b;
        w.abort       = ab;
        if (snd_pct > 0 && $urandom_range(0, 99) < snd_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < snd_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ab, b};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(w);
        n_sent++;
    endtask

    task send_header(logic [31:0] len);
        send_word(len[7:0], 1'b0);
        send_word(len[15:8], 1'b0);
        send_word(len[23:16], 1'b0);
        send_word(len[31:24], 1'b0);
    endtask

    // header then random payload until the block falls back to header phase
    task send_stream(logic [31:0] len, int abort_permille);
        int guard;
        guard = 0;
        send_header(len);
        while (sb.in_payload && guard < PAYLOAD_GUARD)
        begin
            send_word(8'($urandom_range(0, 255)), $urandom_range(0, 999) < abort_permille);
            guard++;
        end
        if (sb.in_payload)
            send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function logic [31:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 95)
            return $urandom_range(13, 60);
        else
            return $urandom_range(100, 300);
    endfunction

    // let the block drain, then write the period while it is idle
    task write_period(logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_period(value);
    endtask

    task set_idling(int mode);
        case (mode)
            0:       begin snd_pct = 0;  recv_pct = 0;  end
            1:       begin snd_pct = 65; recv_pct = 0;  end
            2:       begin snd_pct = 0;  recv_pct = 65; end
            default: begin snd_pct = 20; recv_pct = 20; end
        endcase
    endtask

    task directed_words();
        // zero length finishes on the last header byte
        send_header(32'h0000_0000);
        // nonzero top byte rejects
        send_header(32'hFF00_0005);
        send_header(32'h0100_0000);
        // abort while still in the header
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'hFF, 1'b1);
        // longest legal length, cut short by abort
        send_header(32'h00FF_FFFF);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hA5, 1'b1);
        // length one overruns by the audio byte after the control byte
        send_header(32'h0000_0001);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task random_words(int target);
        int k;
        int n;
        while (n_sent < target)
        begin
            k = $urandom_range(0, 99);
            if (k < 78)
                send_stream(pick_length(), 4);
            else if (k < 84)
                send_header({8'($urandom_range(1, 255)), 24'($urandom)});
            else if (k < 87)
                send_header(32'h0000_0000);
            else if (k < 93)
                send_stream($urandom_range(1, 40), 150);
            else
            begin
                // loose words that may leave the header misaligned
                n = $urandom_range(1, 6);
                repeat (n) send_word(8'($urandom_range(0, 255)),
                                     $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // main sequence: reset, phases of period settings and idling
    initial
    begin
        logic [15:0] periods [PHASES];
        periods[0] = MECH_PERIOD_RESET;
        periods[1] = 16'd1;
        periods[2] = 16'd65535;
        periods[3] = 16'd2;
        periods[4] = 16'd0;
        periods[5] = 16'($urandom_range(1, 8));
        periods[6] = 16'd3;
        periods[7] = 16'($urandom_range(4, 40));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
                write_period(periods[ph]);
            set_idling(ph % 4);
            if (ph == 0)
                directed_words();
            // long receiver hold-off while the sender keeps offering
            if (ph == 0 || ph == 4)
                hold_req = 1;
            random_words(25 + (ph + 1) * (ITEM_TARGET - 25) / PHASES);
        end

        // drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.due_words.size() != 0)
            sb.report("result words still outstanding");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
